>>> src/mma_pkg.sv
// Shared types, command codes and control structs for the matrix multiply-add block.
package mma_pkg;

    localparam int DIM_DEFAULT = 16;
    localparam int IDX_W       = 4;
    localparam int DATA_W      = 32;

    typedef enum logic [1:0] {
        CMD_LOAD_FIRST  = 2'd0,
        CMD_LOAD_SECOND = 2'd1,
        CMD_PRODUCT     = 2'd2,
        CMD_SUM         = 2'd3
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic start;
        logic issue;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic last_issue;
        logic pipe_empty;
        logic out_free;
    } t_ctl_sts;

endpackage

>>> src/mma_if.sv
// Valid/ready channel interfaces for command input (loads and queries) and result output.
interface mma_in_if;
    import mma_pkg::*;
    logic                       valid;
    logic                       ready;
    t_cmd                       cmd;
    logic [IDX_W-1:0]           row_index;
    logic [IDX_W-1:0]           col_index;
    logic signed [DATA_W-1:0]   element_value;

    modport source (output valid, cmd, row_index, col_index, element_value, input ready);
    modport sink   (input valid, cmd, row_index, col_index, element_value, output ready);
endinterface

interface mma_out_if;
    import mma_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [DATA_W-1:0]   result_value;
    logic [IDX_W-1:0]           result_row;
    logic [IDX_W-1:0]           result_col;

    modport source (output valid, result_value, result_row, result_col, input ready);
    modport sink   (input valid, result_value, result_row, result_col, output ready);
endinterface

>>> src/mma_ctrl.sv
// Controller state machine sequencing loads, queries and result hand-off.
module mma_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mma_pkg::t_cmd     i_in_cmd,
    output logic              o_in_ready,
    input  mma_pkg::t_ctl_sts i_sts,
    output mma_pkg::t_ctl_cmd o_cmd
);
    import mma_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_ISSUE  = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;
    logic   is_query;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_query   = (i_in_cmd == CMD_PRODUCT) || (i_in_cmd == CMD_SUM);

    always_comb begin
        n_state        = r_state;
        o_cmd.accept   = accept;
        o_cmd.start    = 1'b0;
        o_cmd.issue    = 1'b0;
        o_cmd.load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_query) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_ISSUE;
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.pipe_empty && i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/mma_datapath.sv
// Matrix storage, multiply-accumulate pipeline and output register.
module mma_datapath #(
    parameter int DIM = mma_pkg::DIM_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mma_pkg::t_ctl_cmd                 i_cmd,
    output mma_pkg::t_ctl_sts                 o_sts,
    input  mma_pkg::t_cmd                     i_in_cmd,
    input  logic [mma_pkg::IDX_W-1:0]         i_row_index,
    input  logic [mma_pkg::IDX_W-1:0]         i_col_index,
    input  logic signed [mma_pkg::DATA_W-1:0] i_element_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mma_pkg::DATA_W-1:0] o_result_value,
    output logic [mma_pkg::IDX_W-1:0]         o_result_row,
    output logic [mma_pkg::IDX_W-1:0]         o_result_col
);
    import mma_pkg::*;

    localparam int DEPTH = DIM * DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int KW    = $clog2(DIM);
    localparam logic [AW-1:0] DIM_A  = AW'(DIM);
    localparam logic [KW-1:0] K_LAST = KW'(DIM - 1);

    logic [DATA_W-1:0] r_mem_a [DEPTH];
    logic [DATA_W-1:0] r_mem_b [DEPTH];

    t_cmd              r_qcmd;
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic              r_inside;
    logic [KW-1:0]     r_k;
    logic              r_rd_vld;
    logic [DATA_W-1:0] r_a_q;
    logic [DATA_W-1:0] r_b_q;
    logic              r_mul_vld;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              r_o_vld;
    logic [DATA_W-1:0] r_res;
    logic [IDX_W-1:0]  r_o_row;
    logic [IDX_W-1:0]  r_o_col;

    logic              in_inside;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic              is_sum;

    assign in_inside = (32'(i_row_index) < DIM) && (32'(i_col_index) < DIM);
    assign wr_addr   = AW'(i_row_index) * DIM_A + AW'(i_col_index);
    assign is_sum    = (r_qcmd == CMD_SUM);
    assign rd_addr_a = AW'(r_row) * DIM_A + (is_sum ? AW'(r_col) : AW'(r_k));
    assign rd_addr_b = is_sum ? AW'(r_row) * DIM_A + AW'(r_col)
                              : AW'(r_k) * DIM_A + AW'(r_col);

    assign o_sts.last_issue = is_sum || (r_k == K_LAST);
    assign o_sts.pipe_empty = !r_rd_vld && !r_mul_vld;
    assign o_sts.out_free   = !r_o_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && in_inside && (i_in_cmd == CMD_LOAD_FIRST)) begin
            r_mem_a[wr_addr] <= DATA_W'($unsigned(i_element_value));
        end
        if (i_cmd.accept && in_inside && (i_in_cmd == CMD_LOAD_SECOND)) begin
            r_mem_b[wr_addr] <= DATA_W'($unsigned(i_element_value));
        end
        if (i_cmd.issue) begin
            r_a_q <= r_mem_a[rd_addr_a];
            r_b_q <= r_mem_b[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_qcmd   <= i_in_cmd;
            r_row    <= i_row_index;
            r_col    <= i_col_index;
            r_inside <= in_inside;
        end
        if (r_rd_vld) begin
            r_prod <= is_sum ? r_a_q + r_b_q : DATA_W'(r_a_q * r_b_q);
        end
        if (i_cmd.start) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + r_prod;
        end
        if (i_cmd.load_out) begin
            r_res   <= r_inside ? r_acc : '0;
            r_o_row <= r_row;
            r_o_col <= r_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k       <= '0;
            r_rd_vld  <= 1'b0;
            r_mul_vld <= 1'b0;
            r_o_vld   <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_k <= '0;
            end else if (i_cmd.issue && (r_k != K_LAST)) begin
                r_k <= r_k + KW'(1);
            end
            r_rd_vld  <= i_cmd.issue;
            r_mul_vld <= r_rd_vld;
            if (i_cmd.load_out) begin
                r_o_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_o_vld;
    assign o_result_value = $signed(r_res);
    assign o_result_row   = r_o_row;
    assign o_result_col   = r_o_col;

endmodule

>>> src/matrix_multiply_add.sv
// Top level of the matrix multiply-add block.
// Loads give no result; the next transfer can be taken in the cycle after a load.
// A product query issues DIM reads through one shared MAC, then passes the operand, product
// and accumulator registers and one output load; a sum query issues a single read.
// After a query, the next transfer waits until its result is loaded, later while a result waits.
// Synchronous active-low reset clears control state; matrix contents stay undefined.
module matrix_multiply_add #(
    parameter int DIM = mma_pkg::DIM_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mma_in_if.sink    i_in,
    mma_out_if.source o_out
);
    import mma_pkg::*;

    t_ctl_cmd ctl_cmd;
    t_ctl_sts ctl_sts;
    logic     in_ready;

    assign i_in.ready = in_ready;

    mma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (in_ready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    mma_datapath #(
        .DIM (DIM)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (ctl_cmd),
        .o_sts           (ctl_sts),
        .i_in_cmd        (i_in.cmd),
        .i_row_index     (i_in.row_index),
        .i_col_index     (i_in.col_index),
        .i_element_value (i_in.element_value),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_result_value  (o_out.result_value),
        .o_result_row    (o_out.result_row),
        .o_result_col    (o_out.result_col)
    );

endmodule
